[rtl/core/btfb_pkg.sv]
// Shared types and constants for the BMP to framebuffer blitter.
package btfb_pkg;

    localparam int unsigned HEADER_BYTES = 54;
    localparam int unsigned WIDTH_POS    = 18;
    localparam int unsigned HEIGHT_POS   = 22;

    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_ORIGIN_ROW = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_ORIGIN_COL = 3'd4;

    typedef struct packed {
        logic [15:0] origin_row;
        logic [15:0] origin_col;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic [31:0] row;
        logic [31:0] col;
        logic [23:0] word;
        logic        last;
    } t_pix;

endpackage

[rtl/core/btfb_byte_if.sv]
// Byte stream channel carrying BMP file bytes.
interface btfb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;

    modport source (output valid, output data_byte, output file_start, input ready);
    modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

[rtl/core/btfb_pix_if.sv]
// Framebuffer write channel carrying one pixel request.
interface btfb_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_index;
    logic [23:0] pixel_word;
    logic        image_last;

    modport source (output valid, output frame_index, output pixel_word, output image_last,
                    input ready);
    modport sink (input valid, input frame_index, input pixel_word, input image_last,
                  output ready);
endinterface

[rtl/core/btfb_parser.sv]
// Header capture, pixel assembly and row tracking for the BMP byte stream.
module btfb_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_data_byte,
    input  logic             i_file_start,
    input  btfb_pkg::t_cfg   i_cfg,
    input  logic             i_adv,
    output btfb_pkg::t_pix   o_pix
);
    import btfb_pkg::*;

    logic [5:0]  r_header_pos, n_header_pos;
    logic [31:0] r_width, n_width;
    logic [31:0] r_height, n_height;
    logic [31:0] r_screen_row, n_screen_row;
    logic [31:0] r_rows_left, n_rows_left;
    logic [31:0] r_col_count, n_col_count;
    logic [1:0]  r_byte_in_pixel, n_byte_in_pixel;
    logic [7:0]  r_blue, n_blue;
    logic [7:0]  r_green, n_green;
    logic [1:0]  r_pad_left, n_pad_left;
    logic        r_active, n_active;
    logic        emit;
    logic        last;
    logic [31:0] col_inc;
    logic [31:0] rows_dec;
    logic [5:0]  pos_inc;
    logic        r_pix_valid;
    logic [31:0] r_pix_row;
    logic [31:0] r_pix_col;
    logic [23:0] r_pix_word;
    logic        r_pix_last;

    assign col_inc  = r_col_count + 32'd1;
    assign rows_dec = r_rows_left - 32'd1;

    always_comb begin
        n_header_pos    = r_header_pos;
        n_width         = r_width;
        n_height        = r_height;
        n_screen_row    = r_screen_row;
        n_rows_left     = r_rows_left;
        n_col_count     = r_col_count;
        n_byte_in_pixel = r_byte_in_pixel;
        n_blue          = r_blue;
        n_green         = r_green;
        n_pad_left      = r_pad_left;
        n_active        = r_active;
        emit            = 1'b0;
        last            = 1'b0;
        pos_inc         = 6'd0;
        if (i_file_start) begin
            n_active     = 1'b1;
            n_header_pos = 6'd0;
            n_width      = 32'd0;
            n_height     = 32'd0;
        end
        if (n_active) begin
            if (n_header_pos < 6'(HEADER_BYTES)) begin
                if (n_header_pos >= 6'(WIDTH_POS) && n_header_pos < 6'(WIDTH_POS + 4)) begin
                    n_width[8*(2'(n_header_pos - 6'(WIDTH_POS)))+:8] =
                        n_width[8*(2'(n_header_pos - 6'(WIDTH_POS)))+:8] | i_data_byte;
                end else if (n_header_pos >= 6'(HEIGHT_POS)
                             && n_header_pos < 6'(HEIGHT_POS + 4)) begin
                    n_height[8*(2'(n_header_pos - 6'(HEIGHT_POS)))+:8] =
                        n_height[8*(2'(n_header_pos - 6'(HEIGHT_POS)))+:8] | i_data_byte;
                end
                pos_inc      = n_header_pos + 6'd1;
                n_header_pos = pos_inc;
                if (pos_inc == 6'(HEADER_BYTES)) begin
                    n_screen_row    = {16'd0, i_cfg.origin_row} + n_height - 32'd1;
                    n_rows_left     = n_height;
                    n_col_count     = 32'd0;
                    n_byte_in_pixel = 2'd0;
                    n_pad_left      = 2'd0;
                    if (n_width == 32'd0 || n_height == 32'd0) begin
                        n_active = 1'b0;
                    end
                end
            end else if (r_pad_left != 2'd0) begin
                n_pad_left = r_pad_left - 2'd1;
            end else if (r_byte_in_pixel == 2'd0) begin
                n_blue          = i_data_byte;
                n_byte_in_pixel = 2'd1;
            end else if (r_byte_in_pixel == 2'd1) begin
                n_green         = i_data_byte;
                n_byte_in_pixel = 2'd2;
            end else begin
                emit            = 1'b1;
                n_byte_in_pixel = 2'd0;
                n_col_count     = col_inc;
                if (col_inc == r_width) begin
                    n_col_count  = 32'd0;
                    n_rows_left  = rows_dec;
                    n_screen_row = r_screen_row - 32'd1;
                    n_pad_left   = r_width[1:0];
                    if (rows_dec == 32'd0) begin
                        last       = 1'b1;
                        n_active   = 1'b0;
                        n_pad_left = 2'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_pos    <= 6'd0;
            r_width         <= 32'd0;
            r_height        <= 32'd0;
            r_screen_row    <= 32'd0;
            r_rows_left     <= 32'd0;
            r_col_count     <= 32'd0;
            r_byte_in_pixel <= 2'd0;
            r_blue          <= 8'd0;
            r_green         <= 8'd0;
            r_pad_left      <= 2'd0;
            r_active        <= 1'b0;
            r_pix_valid     <= 1'b0;
        end else begin
            if (i_fire) begin
                r_header_pos    <= n_header_pos;
                r_width         <= n_width;
                r_height        <= n_height;
                r_screen_row    <= n_screen_row;
                r_rows_left     <= n_rows_left;
                r_col_count     <= n_col_count;
                r_byte_in_pixel <= n_byte_in_pixel;
                r_blue          <= n_blue;
                r_green         <= n_green;
                r_pad_left      <= n_pad_left;
                r_active        <= n_active;
                r_pix_valid     <= emit;
            end else if (i_adv) begin
                r_pix_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && emit) begin
            r_pix_row  <= r_screen_row;
            r_pix_col  <= {16'd0, i_cfg.origin_col} + r_col_count;
            r_pix_word <= {r_blue, r_green, i_data_byte};
            r_pix_last <= last;
        end
    end

    assign o_pix = {r_pix_valid, r_pix_row, r_pix_col, r_pix_word, r_pix_last};
endmodule

[rtl/core/btfb_addr.sv]
// Framebuffer index computation and output register for pixel requests.
module btfb_addr #(
    parameter int unsigned SCREEN_WIDTH = 640
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  btfb_pkg::t_pix i_pix,
    output logic           o_adv,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_frame_index,
    output logic [23:0]    o_pixel_word,
    output logic           o_image_last
);
    import btfb_pkg::*;

    logic        r_valid;
    logic [31:0] r_index;
    logic [23:0] r_word;
    logic        r_last;
    logic [31:0] row_base;

    assign o_adv    = i_pix.valid && (!r_valid || i_ready);
    assign row_base = i_pix.row * 32'(SCREEN_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_index <= row_base + i_pix.col;
            r_word  <= i_pix.word;
            r_last  <= i_pix.last;
        end
    end

    assign o_valid       = r_valid;
    assign o_frame_index = r_index;
    assign o_pixel_word  = r_word;
    assign o_image_last  = r_last;
endmodule

[rtl/core/bmp_to_framebuffer_blitter.sv]
// Top level of the BMP to framebuffer blitter with its configuration registers.
// The block takes one byte of a 24-bit BMP file per cycle and turns every third
// pixel byte into a framebuffer write request; a byte flagged as file start
// restarts parsing. On the red byte of a pixel its request is registered after
// the parser and again after the index multiply by SCREEN_WIDTH. Throughput is
// one byte per cycle, held back only by stalls on the write channel. origin_row
// is sampled when the 54-byte header ends and origin_col at each pixel, so both
// should be written while no file is in flight.
module bmp_to_framebuffer_blitter #(
    parameter int unsigned SCREEN_WIDTH = 640
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    btfb_byte_if.sink                      i_byte,
    btfb_pix_if.source                     o_pix,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [btfb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import btfb_pkg::*;

    t_cfg r_cfg;
    t_pix pix;
    logic in_fire;
    logic adv;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case ({paddr[2], 2'b00})
                ADDR_ORIGIN_ROW: r_cfg.origin_row <= pwdata[15:0];
                ADDR_ORIGIN_COL: r_cfg.origin_col <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case ({paddr[2], 2'b00})
            ADDR_ORIGIN_ROW: prdata = {16'd0, r_cfg.origin_row};
            ADDR_ORIGIN_COL: prdata = {16'd0, r_cfg.origin_col};
            default:         prdata = 32'd0;
        endcase
    end

    assign i_byte.ready = !pix.valid || adv;
    assign in_fire      = i_byte.valid && i_byte.ready;

    btfb_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_data_byte  (i_byte.data_byte),
        .i_file_start (i_byte.file_start),
        .i_cfg        (r_cfg),
        .i_adv        (adv),
        .o_pix        (pix)
    );

    btfb_addr #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_addr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix         (pix),
        .o_adv         (adv),
        .o_valid       (o_pix.valid),
        .i_ready       (o_pix.ready),
        .o_frame_index (o_pix.frame_index),
        .o_pixel_word  (o_pix.pixel_word),
        .o_image_last  (o_pix.image_last)
    );
endmodule
